### sv/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared widths, types and reset constants of the homogeneous point transform.
// ----------------------------------------------------------------------------
`default_nettype none

package hpt_pkg;

  localparam int COORD_W    = 32;
  localparam int MAT_REGS   = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;
  // exact dot product width; holds 3 full products plus the offset term
  localparam int SUM_W      = 66;
  // magnitude of a dot product
  localparam int MAG_W      = SUM_W;
  // divisor 2*|W|
  localparam int B_W        = MAG_W + 1;
  // quotient bits kept before saturation
  localparam int QUOT_W     = 33;

  localparam logic [COORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

  // identity matrix at 16 fractional bits, register 7 first
  localparam logic [MAT_REGS-1:0][CFG_DATA_W-1:0] MAT_RESET = {
    64'd281474976710656, 64'd0, 64'd65536, 64'd0,
    64'd0, 64'd281474976710656, 64'd0, 64'd65536
  };

  typedef struct packed {
    logic       wz;
    logic [2:0] neg;
    logic [2:0] big;
  } ctl_t;

endpackage

`default_nettype wire

### sv/hpt_if.sv
// ----------------------------------------------------------------------------
// hpt_if
// Point, result and configuration channels of the point transform.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpt_pt_if import hpt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface hpt_res_if import hpt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic                      w_zero;
  logic                      overflow;
  modport source (output valid, out_x, out_y, out_z, w_zero, overflow, input ready);
  modport sink   (input valid, out_x, out_y, out_z, w_zero, overflow, output ready);
endinterface

interface hpt_cfg_if import hpt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  addr;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

### sv/hpt_dot.sv
// ----------------------------------------------------------------------------
// hpt_dot
// Two stages: twelve 32x32 products, then the four exact row sums.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_dot import hpt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   en0_i,
  input  logic                                   en1_i,
  input  logic signed [COORD_W-1:0]              point_x_i,
  input  logic signed [COORD_W-1:0]              point_y_i,
  input  logic signed [COORD_W-1:0]              point_z_i,
  input  logic [MAT_REGS-1:0][CFG_DATA_W-1:0]    mat_i,
  output logic signed [SUM_W-1:0]                sum_o [4]
);

  logic signed [COORD_W-1:0]   coord [3];
  logic signed [2*COORD_W-1:0] prod_q [4][3];
  logic signed [COORD_W-1:0]   ofs_q [4];

  assign coord[0] = point_x_i;
  assign coord[1] = point_y_i;
  assign coord[2] = point_z_i;

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int E = 4 * c + r;
      logic signed [COORD_W-1:0] el;
      assign el = $signed(mat_i[E/2][(E%2)*COORD_W +: COORD_W]);
      always_ff @(posedge clk_i) begin
        if (en0_i) begin
          prod_q[r][c] <= el * coord[c];
        end
      end
    end
    localparam int EO = 12 + r;
    always_ff @(posedge clk_i) begin
      if (en0_i) begin
        ofs_q[r] <= $signed(mat_i[EO/2][(EO%2)*COORD_W +: COORD_W]);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en1_i) begin
        sum_o[r] <= SUM_W'(prod_q[r][0]) + SUM_W'(prod_q[r][1]) + SUM_W'(prod_q[r][2])
                    + (SUM_W'(ofs_q[r]) <<< FRAC_BITS);
      end
    end
  end

endmodule

`default_nettype wire

### sv/hpt_prep.sv
// ----------------------------------------------------------------------------
// hpt_prep
// Two stages: magnitudes and rounding offset, then the quotient range check.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_prep import hpt_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int WW        = 101
) (
  input  logic                    clk_i,
  input  logic                    en2_i,
  input  logic                    en3_i,
  input  logic signed [SUM_W-1:0] sum_i [4],
  output logic [WW-1:0]           rem_o [3],
  output logic [B_W-1:0]          b_o,
  output ctl_t                    ctl_o
);

  logic [MAG_W-1:0] mag [4];
  logic [WW-1:0]    a_q [3];
  logic [B_W-1:0]   b_q;
  ctl_t             ctl_q;
  logic [WW-1:0]    b_top;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = sum_i[i][SUM_W-1] ? MAG_W'(-sum_i[i]) : MAG_W'(sum_i[i]);
    end
  end

  // 2*|N|*2^F + |W| over 2*|W| gives the quotient rounded half away from zero
  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      for (int i = 0; i < 3; i++) begin
        a_q[i]       <= (WW'(mag[i]) << (FRAC_BITS + 1)) + WW'(mag[3]);
        ctl_q.neg[i] <= sum_i[i][SUM_W-1] ^ sum_i[3][SUM_W-1];
      end
      b_q       <= {mag[3], 1'b0};
      ctl_q.wz  <= (sum_i[3] == '0);
      ctl_q.big <= '0;
    end
  end

  assign b_top = WW'(b_q) << QUOT_W;

  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      for (int i = 0; i < 3; i++) begin
        rem_o[i]     <= a_q[i];
        ctl_o.big[i] <= (a_q[i] >= b_top);
      end
      ctl_o.neg <= ctl_q.neg;
      ctl_o.wz  <= ctl_q.wz;
      b_o       <= b_q;
    end
  end

endmodule

`default_nettype wire

### sv/hpt_div_step.sv
// ----------------------------------------------------------------------------
// hpt_div_step
// One restoring division step for the three lanes; retires one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_div_step import hpt_pkg::*; #(
  parameter int SHIFT = 0,
  parameter int WW    = 101
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [WW-1:0]     rem_i  [3],
  input  logic [QUOT_W-1:0] quot_i [3],
  input  logic [B_W-1:0]    b_i,
  input  ctl_t              ctl_i,
  output logic [WW-1:0]     rem_o  [3],
  output logic [QUOT_W-1:0] quot_o [3],
  output logic [B_W-1:0]    b_o,
  output ctl_t              ctl_o
);

  logic [WW-1:0] bs;
  logic [WW:0]   diff [3];

  assign bs = WW'(b_i) << SHIFT;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {1'b0, rem_i[i]} - {1'b0, bs};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        rem_o[i]  <= diff[i][WW] ? rem_i[i] : diff[i][WW-1:0];
        quot_o[i] <= {quot_i[i][QUOT_W-2:0], ~diff[i][WW]};
      end
      b_o   <= b_i;
      ctl_o <= ctl_i;
    end
  end

endmodule

`default_nettype wire

### sv/hpt_final.sv
// ----------------------------------------------------------------------------
// hpt_final
// Output register: sign, saturation and the zero-w override.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_final import hpt_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [QUOT_W-1:0]         quot_i [3],
  input  ctl_t                      ctl_i,
  output logic signed [COORD_W-1:0] out_o [3],
  output logic                      w_zero_o,
  output logic                      overflow_o
);

  logic [COORD_W-1:0] val [3];
  logic [2:0]         sat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ctl_i.neg[i]) begin
        sat[i] = ctl_i.big[i] || (quot_i[i] > QUOT_W'(SAT_NEG));
        val[i] = sat[i] ? SAT_NEG : COORD_W'(-quot_i[i]);
      end else begin
        sat[i] = ctl_i.big[i] || (quot_i[i] > QUOT_W'(SAT_POS));
        val[i] = sat[i] ? SAT_POS : quot_i[i][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        out_o[i] <= ctl_i.wz ? '0 : $signed(val[i]);
      end
      w_zero_o   <= ctl_i.wz;
      overflow_o <= ~ctl_i.wz & (|sat);
    end
  end

endmodule

`default_nettype wire

### sv/homogeneous_point_transform_core.sv
// Throughput: one point per cycle; each stage holds only while it is full and
//   the stage after it cannot take its item.
// Depth is set by the 33 restoring division steps, one quotient bit a stage.
// Reset: asynchronous, active low; clears all valid bits and loads the
//   identity matrix (16 fractional bits) into the configuration registers.
// ----------------------------------------------------------------------------
// homogeneous_point_transform_core
// Transforms (x,y,z,1) by a column-major 4x4 matrix and divides by w.
// ----------------------------------------------------------------------------
`default_nettype none

module homogeneous_point_transform_core import hpt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  hpt_pt_if.sink         pt_i,
  hpt_cfg_if.sink        cfg_i,
  hpt_res_if.source      res_o
);

  // stage map: 0 products, 1 sums, 2 magnitudes, 3 range check,
  // 4..36 division steps, 37 output register
  localparam int AW       = MAG_W + FRAC_BITS + 2;
  localparam int BW_TOP   = B_W + QUOT_W;
  localparam int WW       = ((AW > BW_TOP) ? AW : BW_TOP) + 1;
  localparam int DIV_BASE = 4;
  localparam int NST      = DIV_BASE + QUOT_W + 1;

  logic [MAT_REGS-1:0][CFG_DATA_W-1:0] mat_q;
  logic [NST-1:0]                      valid_q, valid_d;
  logic [NST:0]                        en;

  logic signed [SUM_W-1:0]  sum [4];
  logic [WW-1:0]            rem  [QUOT_W+1][3];
  logic [QUOT_W-1:0]        quot [QUOT_W+1][3];
  logic [B_W-1:0]           bdiv [QUOT_W+1];
  ctl_t                     ctl  [QUOT_W+1];
  logic signed [COORD_W-1:0] res [3];

  // configuration: always ready, drop writes beyond the register list
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= MAT_RESET;
    end else if (cfg_i.valid && (cfg_i.addr < CFG_IDX_W'(MAT_REGS))) begin
      mat_q[cfg_i.addr[$clog2(MAT_REGS)-1:0]] <= cfg_i.data;
    end
  end

  // a stage advances when it is empty or its successor advances
  always_comb begin
    en[NST] = res_o.ready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = ~valid_q[k] | en[k+1];
    end
    valid_d[0] = en[0] ? pt_i.valid : valid_q[0];
    for (int k = 1; k < NST; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign pt_i.ready = en[0];

  hpt_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
    .clk_i     (clk_i),
    .en0_i     (en[0]),
    .en1_i     (en[1]),
    .point_x_i (pt_i.point_x),
    .point_y_i (pt_i.point_y),
    .point_z_i (pt_i.point_z),
    .mat_i     (mat_q),
    .sum_o     (sum)
  );

  hpt_prep #(.FRAC_BITS(FRAC_BITS), .WW(WW)) u_prep (
    .clk_i (clk_i),
    .en2_i (en[2]),
    .en3_i (en[3]),
    .sum_i (sum),
    .rem_o (rem[0]),
    .b_o   (bdiv[0]),
    .ctl_o (ctl[0])
  );

  for (genvar i = 0; i < 3; i++) begin : g_q0
    assign quot[0][i] = '0;
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < QUOT_W; j++) begin : g_div
    hpt_div_step #(.SHIFT(QUOT_W - 1 - j), .WW(WW)) u_step (
      .clk_i  (clk_i),
      .en_i   (en[DIV_BASE + j]),
      .rem_i  (rem[j]),
      .quot_i (quot[j]),
      .b_i    (bdiv[j]),
      .ctl_i  (ctl[j]),
      .rem_o  (rem[j+1]),
      .quot_o (quot[j+1]),
      .b_o    (bdiv[j+1]),
      .ctl_o  (ctl[j+1])
    );
  end

  hpt_final u_final (
    .clk_i      (clk_i),
    .en_i       (en[NST-1]),
    .quot_i     (quot[QUOT_W]),
    .ctl_i      (ctl[QUOT_W]),
    .out_o      (res),
    .w_zero_o   (res_o.w_zero),
    .overflow_o (res_o.overflow)
  );

  assign res_o.valid = valid_q[NST-1];
  assign res_o.out_x = res[0];
  assign res_o.out_y = res[1];
  assign res_o.out_z = res[2];

endmodule

`default_nettype wire

### sv/hpt_checker.sv
// ----------------------------------------------------------------------------
// hpt_checker
// Port-level checks of the point transform, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hpt_checker import hpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  input  logic               res_ready_i,
  input  logic [COORD_W-1:0] out_x_i,
  input  logic [COORD_W-1:0] out_y_i,
  input  logic [COORD_W-1:0] out_z_i,
  input  logic               w_zero_i,
  input  logic               overflow_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i
);

  // zero w forces a clean zero result
  a_wzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && w_zero_i |->
      out_x_i == '0 && out_y_i == '0 && out_z_i == '0 && !overflow_i)
    else $error("zero-w result not cleared");

  // an overflow shows at least one saturated coordinate
  a_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && overflow_i |->
      out_x_i == SAT_POS || out_x_i == SAT_NEG || out_y_i == SAT_POS ||
      out_y_i == SAT_NEG || out_z_i == SAT_POS || out_z_i == SAT_NEG)
    else $error("overflow without saturated output");

  // nothing comes out right after reset
  a_rst : assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !res_valid_i)
    else $error("result valid out of reset");

  a_cfg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("configuration write stalled");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(out_x_i))
    else $error("stalled result dropped");

endmodule

bind homogeneous_point_transform_core hpt_checker u_hpt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .out_x_i     (res_o.out_x),
  .out_y_i     (res_o.out_y),
  .out_z_i     (res_o.out_z),
  .w_zero_i    (res_o.w_zero),
  .overflow_i  (res_o.overflow),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready)
);

`default_nettype wire

### dv/homogeneous_point_transform_core_test.sv
// ----------------------------------------------------------------------------
// homogeneous_point_transform_core_test
// Drives points and matrix writes into the point transform and checks every
// projected result against a bit-exact predictor of the rounded, saturated
// perspective divide, under random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module homogeneous_point_transform_core_test;
  import hpt_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 38;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RAND_POINTS = 1200;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               wz;
    logic               ovf;
  } proj_t;

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    bit          typed;  // expected result typed in below
    proj_t       want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hpt_pt_if  pt_if ();
  hpt_cfg_if cfg_if ();
  hpt_res_if res_if ();

  homogeneous_point_transform_core #(.FRAC_BITS(FRAC)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pt_i  (pt_if.sink),
    .cfg_i (cfg_if.sink),
    .res_o (res_if.source)
  );

  // Predictor's own copy of the matrix registers.
  logic [63:0] mat_shadow [MAT_REGS];
  proj_t       pending_proj [$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;     // no idling in the last part of the run
  int          sink_gap = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Bound the run; a hang counts as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic signed [31:0] mat_elem(int e);
    logic [63:0] word;
    word = mat_shadow[e >> 1];
    return (e & 1) ? word[63:32] : word[31:0];
  endfunction

  // Rounded (ties away from zero), saturated num * 2^FRAC / den.
  function automatic logic [31:0] divide_proj(logic signed [69:0] num,
                                              logic signed [69:0] den,
                                              ref bit ovf);
    logic [69:0]  mn;
    logic [69:0]  md;
    logic [127:0] q;
    bit           neg;
    mn = num[69] ? -num : num;
    md = den[69] ? -den : den;
    neg = num[69] ^ den[69];
    q = ((128'(mn) << (FRAC + 1)) + 128'(md)) / (128'(md) << 1);
    if (!neg) begin
      if (q > 128'h7FFF_FFFF) begin
        ovf = 1'b1;
        return SAT_POS;
      end
      return q[31:0];
    end
    if (q > 128'h8000_0000) begin
      ovf = 1'b1;
      return SAT_NEG;
    end
    return -q[31:0];
  endfunction

  function automatic proj_t project_point(logic signed [31:0] px,
                                          logic signed [31:0] py,
                                          logic signed [31:0] pz);
    logic signed [69:0] acc [4];
    logic signed [31:0] p [3];
    proj_t              r;
    bit                 ovf;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    ovf = 1'b0;
    r = '0;
    for (int row = 0; row < 4; row++) begin
      acc[row] = 70'(mat_elem(12 + row)) <<< FRAC;
      for (int c = 0; c < 3; c++)
        acc[row] += 70'(mat_elem(c * 4 + row)) * 70'(p[c]);
    end
    if (acc[3] == 0) begin
      r.wz = 1'b1;
      return r;
    end
    r.x = divide_proj(acc[0], acc[3], ovf);
    r.y = divide_proj(acc[1], acc[3], ovf);
    r.z = divide_proj(acc[2], acc[3], ovf);
    r.ovf = ovf;
    return r;
  endfunction

  // Result side: random stall bursts, compare with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    proj_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (pending_proj.size() == 0) begin
          $error("result with no point outstanding");
          fail_count++;
        end else begin
          want = pending_proj.pop_front();
          if (res_if.out_x !== want.x) begin
            $error("out_x exp %h got %h", want.x, res_if.out_x); fail_count++;
          end
          if (res_if.out_y !== want.y) begin
            $error("out_y exp %h got %h", want.y, res_if.out_y); fail_count++;
          end
          if (res_if.out_z !== want.z) begin
            $error("out_z exp %h got %h", want.z, res_if.out_z); fail_count++;
          end
          if (res_if.w_zero !== want.wz) begin
            $error("w_zero exp %b got %b", want.wz, res_if.w_zero); fail_count++;
          end
          if (res_if.overflow !== want.ovf) begin
            $error("overflow exp %b got %b", want.ovf, res_if.overflow); fail_count++;
          end
        end
      end
      if (sink_gap > 0) begin
        res_if.ready <= 1'b0;
        sink_gap <= sink_gap - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        res_if.ready <= 1'b0;
        sink_gap <= $urandom_range(0, 5);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Write one matrix register; the block must be idle. Drop valid after the
  // write so the next write starts on a later edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx < MAT_REGS) mat_shadow[idx] = val;
    @(posedge clk_i);
  endtask

  // Send one point, with a random idle burst first; queue its expectation.
  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            bit typed, proj_t want);
    int gap;
    proj_t pred;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 6);
      pt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pt_if.valid   <= 1'b1;
    pt_if.point_x <= px;
    pt_if.point_y <= py;
    pt_if.point_z <= pz;
    pred = project_point(px, py, pz);
    if (typed && pred !== want) begin
      $error("typed row disagrees: exp %h pred %h", want, pred);
      fail_count++;
    end
    pending_proj.push_back(typed ? want : pred);
    do @(posedge clk_i); while (!pt_if.ready);
  endtask

  task automatic drain();
    pt_if.valid <= 1'b0;
    while (pending_proj.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 8) << 16;
      3: return -($urandom_range(0, 8) << 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] rand_pair();
    logic [31:0] h [2];
    for (int k = 0; k < 2; k++)
      case ($urandom_range(0, 4))
        0: h[k] = 32'(($urandom_range(0, 4) - 2) <<< 16);
        1: h[k] = $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
        2: h[k] = 32'($signed($urandom_range(0, 2 ** 18)) - (2 ** 17));
        default: h[k] = $urandom;
      endcase
    return {h[1], h[0]};
  endfunction

  // Directed table: identity after reset; w is forced to zero in the next table.
  row_t rows [] = '{
    '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1,
      '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0, 1'b0}},
    '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b1,
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0}},
    '{32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 1'b1,
      '{32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 1'b0, 1'b0}},
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, '0}
  };

  // Rows after writing the w row all-zero (upper halves of registers 1, 3, 5, 7).
  row_t wz_rows [] = '{
    '{32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
      '{32'h0, 32'h0, 32'h0, 1'b1, 1'b0}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{32'h0, 32'h0, 32'h0, 1'b1, 1'b0}}
  };

  initial begin
    proj_t none;
    none = '0;
    for (int i = 0; i < MAT_REGS; i++) mat_shadow[i] = MAT_RESET[i];
    pt_if.valid = 1'b0;
    pt_if.point_x = '0;
    pt_if.point_y = '0;
    pt_if.point_z = '0;
    cfg_if.valid = 1'b0;
    cfg_if.addr = '0;
    cfg_if.data = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_point(rows[i].px, rows[i].py, rows[i].pz,
                                 rows[i].typed, rows[i].want);
    drain();

    // Zero the w row: elements 3, 7, 11, 15.
    write_reg(1, {32'h0, mat_shadow[1][31:0]});
    write_reg(3, {32'h0, mat_shadow[3][31:0]});
    write_reg(5, {32'h0, mat_shadow[5][31:0]});
    write_reg(7, {32'h0, mat_shadow[7][31:0]});
    write_reg(4'hF, 64'hFFFF_FFFF_FFFF_FFFF);  // out-of-range index, ignored
    foreach (wz_rows[i]) send_point(wz_rows[i].px, wz_rows[i].py, wz_rows[i].pz,
                                    wz_rows[i].typed, wz_rows[i].want);
    drain();

    // Extremes: all elements at the most negative, then most positive value;
    // small w with large numerators drives saturation, negative w flips sign.
    for (int m = 0; m < 3; m++) begin
      for (int r = 0; r < MAT_REGS; r++)
        write_reg(r, m == 0 ? 64'h8000_0000_8000_0000 :
                     m == 1 ? 64'h7FFF_FFFF_7FFF_FFFF :
                     (r == 7 ? 64'hFFFF_FFFF_0000_0000 : 64'h7FFF_FFFF_8000_0000));
      for (int k = 0; k < 6; k++)
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, none);
      drain();
    end

    // Random phases, each with a fresh matrix; the last one runs without idling.
    for (int ph = 0; ph < 12; ph++) begin
      for (int r = 0; r < MAT_REGS; r++) write_reg(r, rand_pair());
      if ($urandom_range(0, 3) == 0) write_reg(7, {32'h0, mat_shadow[7][31:0]});
      calm = (ph == 11);
      for (int k = 0; k < RAND_POINTS / 12; k++)
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, none);
      drain();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
